// File: design/pwmrc_pkg.sv
// pwmrc_pkg: shared types, widths and constants of the pwm prescaler and reload calculator
package pwmrc_pkg;

   // request and result beats
   typedef struct packed {
      logic        func;
      logic [31:0] target_freq_hz;
      logic [16:0] duty_request;
      logic [2:0]  channel_sel;
   } req_type;

   typedef struct packed {
      logic [15:0] prescale_value;
      logic [31:0] reload_value;
      logic [31:0] compare_value;
      logic [2:0]  channel_out;
      logic [41:0] achieved_freq_mhz;
      logic [16:0] duty_step;
      logic [16:0] duty_out;
      logic [1:0]  status;
   } rsp_type;

   // operation selector
   localparam logic FUNC_COMPUTE = 1'b0;

   // status codes
   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_ZERO_FREQ   = 2'd1;
   localparam logic [1:0] STATUS_RELOAD_ZERO = 2'd2;
   localparam logic [1:0] STATUS_PRESC_OVF   = 2'd3;

   // register indexes
   localparam logic CSR_CLOCK_HZ = 1'b0;
   localparam logic CSR_WIDE     = 1'b1;

   localparam int CSR_DATA_W = 32;

   // serial divider sizes
   localparam int DIV_NUM_W = 51;
   localparam int DIV_DEN_W = 34;
   localparam int DIV_CNT_W = 6;

   // serial multiplier sizes
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 17;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = 5;

   // top numerator bit of each division
   localparam logic [DIV_CNT_W-1:0] TOP_CLK2    = 6'd32;
   localparam logic [DIV_CNT_W-1:0] TOP_FMILLI  = 6'd42;
   localparam logic [DIV_CNT_W-1:0] TOP_COMPARE = 6'd50;
   localparam logic [DIV_CNT_W-1:0] TOP_STEP    = 6'd17;

   // counter limits and the matching 2L+1 divisors
   localparam logic [31:0] LIM_NARROW = 32'h0000_ffff;
   localparam logic [31:0] LIM_WIDE   = 32'hffff_ffff;
   localparam logic [DIV_DEN_W-1:0] DEN_NARROW = 34'h0_0001_ffff;
   localparam logic [DIV_DEN_W-1:0] DEN_WIDE   = 34'h1_ffff_ffff;

   // duty and frequency scaling
   localparam logic [17:0] FULL_DUTY      = 18'd102400;
   localparam logic [17:0] FULL_DUTY_X2   = 18'd204800;
   localparam logic [MUL_B_W-1:0] MILLI_X2 = 17'd2000;

   localparam logic [31:0] CLOCK_HZ_RESET = 32'd200000000;

endpackage

// File: design/pwm_prescaler_reload_calc_unit.sv
// pwm_prescaler_reload_calc_unit: top level, sequencer around a shared serial divider and multiplier
// the full path runs every state; prescaler overflow skips the reload divisions, a zero reload
//   ends after them, and a zero frequency goes straight to the result strobe
// a division and a product each take one bit per cycle
// one beat at a time: start is taken in the cycle after the strobe
// the receiver cannot stall: the result is shown for exactly one cycle on rsp_strobe
// synchronous reset returns to idle, clock register to 200 mhz and the counter to 16 bits
module pwm_prescaler_reload_calc_unit #(
   parameter int PRESCALER_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                start,
   output logic                                busy,
   input  pwmrc_pkg::req_type                  req_payload,
   // result channel
   output logic                                rsp_strobe,
   output pwmrc_pkg::rsp_type                  rsp_payload,
   // configuration writes
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [pwmrc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int NW = pwmrc_pkg::DIV_NUM_W;
   localparam int DW = pwmrc_pkg::DIV_DEN_W;
   localparam int CW = pwmrc_pkg::DIV_CNT_W;

   // prescaler width: the search never gives more than 65537, saturation gives 2^PRESCALER_BITS
   localparam int P_W = (PRESCALER_BITS + 1 > 17) ? PRESCALER_BITS + 1 : 17;
   localparam logic [P_W-1:0] P_MAX = P_W'({1'b1, {PRESCALER_BITS{1'b0}}});

   // one-hot sequencer
   typedef enum logic [11:0] {
      ST_IDLE = 12'b0000_0000_0001,  // waiting for a request
      ST_QLIM = 12'b0000_0000_0010,  // 2clk / (2L+1)
      ST_QPRE = 12'b0000_0000_0100,  // then / f gives the prescaler
      ST_RCLK = 12'b0000_0000_1000,  // 2clk / p
      ST_RFRQ = 12'b0000_0001_0000,  // then / f gives the reload
      ST_MULC = 12'b0000_0010_0000,  // duty * reload
      ST_DIVC = 12'b0000_0100_0000,  // rounded compare
      ST_MULF = 12'b0000_1000_0000,  // 2000 * clk
      ST_FPRE = 12'b0001_0000_0000,  // / p
      ST_FREL = 12'b0010_0000_0000,  // / r gives the achieved frequency
      ST_STEP = 12'b0100_0000_0000,  // duty step
      ST_DONE = 12'b1000_0000_0000   // result strobe
   } state_type;

   state_type           state_ff, state_in;
   logic                first_ff, first_in;      // first cycle in a state, launches the unit
   logic [31:0]         clock_hz_ff, clock_hz_in;
   logic                wide_ff, wide_in;

   logic [31:0]         freq_ff, freq_in;
   logic [16:0]         duty_ff, duty_in;
   logic [NW-1:0]       tmp_ff, tmp_in;          // intermediate quotient or product
   logic [P_W-1:0]      p_ff, p_in;
   logic [31:0]         r_ff, r_in;
   pwmrc_pkg::rsp_type  rsp_ff, rsp_in;

   // shared units
   logic                div_start, div_done;
   logic [NW-1:0]       div_num, div_quot;
   logic [DW-1:0]       div_den;
   logic [CW-1:0]       div_top;
   logic                mul_start, mul_done;
   logic [pwmrc_pkg::MUL_A_W-1:0] mul_a;
   logic [pwmrc_pkg::MUL_B_W-1:0] mul_b;
   logic [pwmrc_pkg::MUL_P_W-1:0] mul_prod;

   // rounding and search helpers
   logic [P_W-1:0]      p_calc, p_fin;
   logic                p_over;
   logic [33:0]         r_sum;
   logic [31:0]         r_calc;
   logic [43:0]         f_sum;
   logic [18:0]         s_sum;
   logic [31:0]         lim;
   logic                accept;

   assign accept = start & ~busy;
   assign lim    = wide_ff ? pwmrc_pkg::LIM_WIDE : pwmrc_pkg::LIM_NARROW;

   // smallest prescaler, saturated when even the largest one is too small
   assign p_calc = P_W'(div_quot) + P_W'(1);
   assign p_over = p_calc > P_MAX;
   assign p_fin  = p_over ? P_MAX : p_calc;

   // halves round up: (q + 1) >> 1
   assign r_sum  = {1'b0, div_quot[32:0]} + 34'd1;
   assign r_calc = r_sum[32:1];
   assign f_sum  = {1'b0, div_quot[42:0]} + 44'd1;
   assign s_sum  = {1'b0, div_quot[17:0]} + 19'd1;

   // unit launch on the first cycle of each working state
   assign div_start = first_ff & (state_ff != ST_IDLE) & (state_ff != ST_DONE)
                      & (state_ff != ST_MULC) & (state_ff != ST_MULF);
   assign mul_start = first_ff & ((state_ff == ST_MULC) | (state_ff == ST_MULF));

   // operand selection for the shared units
   always_comb begin
      div_num = tmp_ff;
      div_den = DW'(freq_ff);
      div_top = pwmrc_pkg::TOP_CLK2;
      mul_a   = r_ff;
      mul_b   = duty_ff;
      unique case (state_ff)
         ST_QLIM: begin
            div_num = NW'({clock_hz_ff, 1'b0});
            div_den = wide_ff ? pwmrc_pkg::DEN_WIDE : pwmrc_pkg::DEN_NARROW;
         end
         ST_QPRE: begin
            div_den = DW'(freq_ff);
         end
         ST_RCLK: begin
            div_num = NW'({clock_hz_ff, 1'b0});
            div_den = DW'(p_ff);
         end
         ST_RFRQ: begin
            div_den = DW'(freq_ff);
         end
         ST_DIVC: begin
            div_den = DW'(pwmrc_pkg::FULL_DUTY_X2);
            div_top = pwmrc_pkg::TOP_COMPARE;
         end
         ST_MULF: begin
            mul_a = clock_hz_ff;
            mul_b = pwmrc_pkg::MILLI_X2;
         end
         ST_FPRE: begin
            div_den = DW'(p_ff);
            div_top = pwmrc_pkg::TOP_FMILLI;
         end
         ST_FREL: begin
            div_den = DW'(r_ff);
            div_top = pwmrc_pkg::TOP_FMILLI;
         end
         ST_STEP: begin
            div_num = NW'(pwmrc_pkg::FULL_DUTY_X2);
            div_den = DW'(r_ff);
            div_top = pwmrc_pkg::TOP_STEP;
         end
         default: begin
            div_num = tmp_ff;
         end
      endcase
   end

   // sequencer and result assembly
   always_comb begin
      state_in    = state_ff;
      first_in    = 1'b0;
      clock_hz_in = clock_hz_ff;
      wide_in     = wide_ff;
      freq_in     = freq_ff;
      duty_in     = duty_ff;
      tmp_in      = tmp_ff;
      p_in        = p_ff;
      r_in        = r_ff;
      rsp_in      = rsp_ff;

      // configuration writes
      if (csr_we) begin
         unique case (csr_index)
            pwmrc_pkg::CSR_CLOCK_HZ: clock_hz_in = csr_wdata;
            pwmrc_pkg::CSR_WIDE:     wide_in     = csr_wdata[0];
            default:                 clock_hz_in = clock_hz_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            // other selectors are taken and dropped without a result
            if (accept && req_payload.func == pwmrc_pkg::FUNC_COMPUTE) begin
               freq_in            = req_payload.target_freq_hz;
               duty_in            = req_payload.duty_request;
               rsp_in             = '0;
               rsp_in.channel_out = req_payload.channel_sel;
               rsp_in.duty_out    = req_payload.duty_request;
               first_in           = 1'b1;
               if (req_payload.target_freq_hz == '0) begin
                  rsp_in.status = pwmrc_pkg::STATUS_ZERO_FREQ;
                  state_in      = ST_DONE;
               end else begin
                  rsp_in.status = pwmrc_pkg::STATUS_OK;
                  state_in      = ST_QLIM;
               end
            end
         end
         ST_QLIM: begin
            if (div_done) begin
               tmp_in   = div_quot;
               state_in = ST_QPRE;
               first_in = 1'b1;
            end
         end
         ST_QPRE: begin
            if (div_done) begin
               p_in                  = p_fin;
               rsp_in.prescale_value = 16'(p_fin - P_W'(1));
               first_in              = 1'b1;
               if (p_over) begin
                  // saturate prescaler and reload
                  r_in                = lim;
                  rsp_in.reload_value = lim - 32'd1;
                  rsp_in.status       = pwmrc_pkg::STATUS_PRESC_OVF;
                  state_in            = ST_MULC;
               end else begin
                  state_in = ST_RCLK;
               end
            end
         end
         ST_RCLK: begin
            if (div_done) begin
               tmp_in   = div_quot;
               state_in = ST_RFRQ;
               first_in = 1'b1;
            end
         end
         ST_RFRQ: begin
            if (div_done) begin
               r_in     = r_calc;
               first_in = 1'b1;
               if (r_calc == '0) begin
                  rsp_in.prescale_value = '0;
                  rsp_in.status         = pwmrc_pkg::STATUS_RELOAD_ZERO;
                  state_in              = ST_DONE;
               end else begin
                  rsp_in.reload_value = r_calc - 32'd1;
                  state_in            = ST_MULC;
               end
            end
         end
         ST_MULC: begin
            if (mul_done) begin
               // 2*d*r + full duty, rounded by the next division
               tmp_in   = NW'({mul_prod, 1'b0}) + NW'(pwmrc_pkg::FULL_DUTY);
               state_in = ST_DIVC;
               first_in = 1'b1;
            end
         end
         ST_DIVC: begin
            if (div_done) begin
               // zero compare wraps to all ones
               rsp_in.compare_value = div_quot[31:0] - 32'd1;
               state_in             = ST_MULF;
               first_in             = 1'b1;
            end
         end
         ST_MULF: begin
            if (mul_done) begin
               tmp_in   = NW'(mul_prod);
               state_in = ST_FPRE;
               first_in = 1'b1;
            end
         end
         ST_FPRE: begin
            if (div_done) begin
               tmp_in   = div_quot;
               state_in = ST_FREL;
               first_in = 1'b1;
            end
         end
         ST_FREL: begin
            if (div_done) begin
               rsp_in.achieved_freq_mhz = f_sum[42:1];
               state_in                 = ST_STEP;
               first_in                 = 1'b1;
            end
         end
         ST_STEP: begin
            if (div_done) begin
               rsp_in.duty_step = s_sum[17:1];
               state_in         = ST_DONE;
               first_in         = 1'b1;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         first_ff    <= 1'b0;
         clock_hz_ff <= pwmrc_pkg::CLOCK_HZ_RESET;
         wide_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         first_ff    <= first_in;
         clock_hz_ff <= clock_hz_in;
         wide_ff     <= wide_in;
      end
      freq_ff <= freq_in;
      duty_ff <= duty_in;
      tmp_ff  <= tmp_in;
      p_ff    <= p_in;
      r_ff    <= r_in;
      rsp_ff  <= rsp_in;
   end

   pwmrc_serial_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num     (div_num),
      .den     (div_den),
      .top_bit (div_top),
      .done    (div_done),
      .quot    (div_quot)
   );

   pwmrc_serial_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_strobe  = (state_ff == ST_DONE);
   assign rsp_payload = rsp_ff;

   // a result beat lasts one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // an unknown selector is dropped and leaves the block idle
   a_func_dropped: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.func != pwmrc_pkg::FUNC_COMPUTE) |=> !busy)
      else $error("unknown selector started a calculation");

   // the divider is never launched with a zero divisor
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (div_den != '0))
      else $error("divider launched with zero divisor");

   // zero frequency gives the fixed empty result
   a_zero_freq: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.status == pwmrc_pkg::STATUS_ZERO_FREQ)
      |-> (rsp_payload.reload_value == '0 && rsp_payload.achieved_freq_mhz == '0))
      else $error("zero frequency result carries non-zero fields");

endmodule

// File: design/pwmrc_serial_div.sv
// pwmrc_serial_div: restoring divider, one quotient bit per cycle
module pwmrc_serial_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [pwmrc_pkg::DIV_NUM_W-1:0]      num,
   input  logic [pwmrc_pkg::DIV_DEN_W-1:0]      den,
   input  logic [pwmrc_pkg::DIV_CNT_W-1:0]      top_bit,
   output logic                                 done,
   output logic [pwmrc_pkg::DIV_NUM_W-1:0]      quot
);

   localparam int NW = pwmrc_pkg::DIV_NUM_W;
   localparam int DW = pwmrc_pkg::DIV_DEN_W;
   localparam int CW = pwmrc_pkg::DIV_CNT_W;

   logic          active_ff, active_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] num_ff, num_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [NW-1:0] quot_ff, quot_in;

   logic [DW:0]   rem_sh;
   logic [DW+1:0] diff;
   logic          qbit;

   // shift in next numerator bit, trial subtract
   assign rem_sh = {rem_ff, num_ff[cnt_ff]};
   assign diff   = {1'b0, rem_sh} - {2'b00, den_ff};
   assign qbit   = ~diff[DW+1];

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      quot_in   = quot_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = top_bit;
         num_in    = num;
         den_in    = den;
         rem_in    = '0;
         quot_in   = '0;
      end else if (active_ff) begin
         rem_in  = qbit ? diff[DW-1:0] : rem_sh[DW-1:0];
         quot_in = {quot_ff[NW-2:0], qbit};
         if (cnt_ff == '0) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end else begin
            cnt_in = cnt_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      cnt_ff  <= cnt_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// File: design/pwmrc_serial_mul.sv
// pwmrc_serial_mul: shift-add multiplier, one multiplier bit per cycle
module pwmrc_serial_mul (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [pwmrc_pkg::MUL_A_W-1:0]    a,
   input  logic [pwmrc_pkg::MUL_B_W-1:0]    b,
   output logic                             done,
   output logic [pwmrc_pkg::MUL_P_W-1:0]    prod
);

   localparam int AW = pwmrc_pkg::MUL_A_W;
   localparam int BW = pwmrc_pkg::MUL_B_W;
   localparam int PW = pwmrc_pkg::MUL_P_W;
   localparam int CW = pwmrc_pkg::MUL_CNT_W;

   logic          active_ff, active_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0] a_ff, a_in;
   logic [BW-1:0] b_ff, b_in;
   logic [PW-1:0] acc_ff, acc_in;

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      acc_in    = acc_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = CW'(BW - 1);
         a_in      = PW'(a);
         b_in      = b;
         acc_in    = '0;
      end else if (active_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in = {a_ff[PW-2:0], 1'b0};
         b_in = {1'b0, b_ff[BW-1:1]};
         if (cnt_ff == '0) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end else begin
            cnt_in = cnt_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

// File: bench/pwm_prescaler_reload_calc_unit_test.sv
// pwm_prescaler_reload_calc_unit_test: self-checking bench for the pwm prescaler and reload calculator
`timescale 1ns / 1ps

module pwm_prescaler_reload_calc_unit_test;

   localparam int PRESCALER_BITS = 16;
   localparam logic [63:0] PRESC_MAX = 64'd1 << PRESCALER_BITS;
   // the only other selector value, which the block drops without a result
   localparam logic FUNC_IGNORED = ~pwmrc_pkg::FUNC_COMPUTE;

   // longer than the full path, so this covers any beat still in flight
   localparam int LATENCY = 400;
   localparam int DRAIN_LIMIT = 20 * LATENCY;
   localparam int ITEMS_PER_PHASE = 200;
   localparam int RANDOM_PHASES = 10;
   localparam int PLAN_ROWS = 27;

   localparam logic        FC = pwmrc_pkg::FUNC_COMPUTE;
   localparam logic [1:0]  S_OK = pwmrc_pkg::STATUS_OK;
   localparam logic [1:0]  S_ZF = pwmrc_pkg::STATUS_ZERO_FREQ;
   localparam logic [1:0]  S_RZ = pwmrc_pkg::STATUS_RELOAD_ZERO;

   typedef enum logic {ROW_BEAT, ROW_SETUP} row_kind_type;

   // one row of the directed plan; on a beat row a status other than ok means the
   // result is typed in (all computed fields zero), ok means the predictor works it out
   typedef struct {
      row_kind_type kind;
      logic        func;
      logic [31:0] freq;
      logic [16:0] duty;
      logic [2:0]  chan;
      logic [1:0]  fixed_status;
      logic [31:0] clk_hz;
      logic        wide;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   pwmrc_pkg::req_type req_payload = '0;
   logic rsp_strobe;
   pwmrc_pkg::rsp_type rsp_payload;
   logic csr_we = 1'b0;
   logic csr_index = pwmrc_pkg::CSR_CLOCK_HZ;
   logic [pwmrc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // bench copy of the two configuration registers
   logic [31:0] clock_hz_setting = pwmrc_pkg::CLOCK_HZ_RESET;
   logic        wide_setting = 1'b0;

   pwmrc_pkg::rsp_type settings_due [$];
   int unsigned mismatches = 0;
   int unsigned results_seen = 0;
   int unsigned idle_pct = 11;

   // directed plan: reset defaults first, then the clock and counter extremes
   plan_row_type plan [0:PLAN_ROWS-1] = '{
      // zero frequency, with duty and channel extremes passed through
      '{ROW_BEAT,  FC,           32'd0,         17'd0,      3'd0, S_ZF, 32'd0,         1'b0},
      '{ROW_BEAT,  FC,           32'd0,         17'h1ffff,  3'd7, S_ZF, 32'd0,         1'b0},
      // above twice the clock the reload rounds to nothing
      '{ROW_BEAT,  FC,           32'hffff_ffff, 17'd102400, 3'd5, S_RZ, 32'd0,         1'b0},
      '{ROW_BEAT,  FC,           32'd400000001, 17'd51200,  3'd2, S_RZ, 32'd0,         1'b0},
      // exactly twice the clock: reload of one, a half rounded up
      '{ROW_BEAT,  FC,           32'd400000000, 17'd102400, 3'd1, S_OK, 32'd0,         1'b0},
      '{ROW_BEAT,  FC,           32'd1,         17'd0,      3'd2, S_OK, 32'd0,         1'b0},
      '{ROW_BEAT,  FC,           32'd1,         17'h1ffff,  3'd3, S_OK, 32'd0,         1'b0},
      '{ROW_BEAT,  FC,           32'd1000,      17'd51200,  3'd4, S_OK, 32'd0,         1'b0},
      '{ROW_BEAT,  FC,           32'd20000,     17'd1,      3'd6, S_OK, 32'd0,         1'b0},
      // other selector: dropped, nothing comes back
      '{ROW_BEAT,  FUNC_IGNORED, 32'd1000,      17'd100,    3'd0, S_OK, 32'd0,         1'b0},
      '{ROW_BEAT,  FC,           32'h0000_aaaa, 17'h0aaaa,  3'd5, S_OK, 32'd0,         1'b0},
      '{ROW_BEAT,  FC,           32'h0000_5555, 17'h15555,  3'd2, S_OK, 32'd0,         1'b0},
      '{ROW_SETUP, FC,           32'd0,         17'd0,      3'd0, S_OK, 32'd200000000, 1'b1},
      '{ROW_BEAT,  FC,           32'd1,         17'd102400, 3'd0, S_OK, 32'd0,         1'b0},
      '{ROW_BEAT,  FC,           32'd3,         17'h1ffff,  3'd7, S_OK, 32'd0,         1'b0},
      // fastest clock on a 16-bit counter: prescaler runs out of range at 1 hz
      '{ROW_SETUP, FC,           32'd0,         17'd0,      3'd0, S_OK, 32'hffff_ffff, 1'b0},
      '{ROW_BEAT,  FC,           32'd1,         17'd0,      3'd1, S_OK, 32'd0,         1'b0},
      '{ROW_BEAT,  FC,           32'd1,         17'h1ffff,  3'd7, S_OK, 32'd0,         1'b0},
      '{ROW_BEAT,  FC,           32'd2,         17'd102400, 3'd3, S_OK, 32'd0,         1'b0},
      // stopped clock: every non-zero frequency rounds to nothing
      '{ROW_SETUP, FC,           32'd0,         17'd0,      3'd0, S_OK, 32'd0,         1'b0},
      '{ROW_BEAT,  FC,           32'd1,         17'd51200,  3'd4, S_RZ, 32'd0,         1'b0},
      '{ROW_BEAT,  FC,           32'd0,         17'd51200,  3'd4, S_ZF, 32'd0,         1'b0},
      // slowest running clock on the wide counter
      '{ROW_SETUP, FC,           32'd0,         17'd0,      3'd0, S_OK, 32'd1,         1'b1},
      '{ROW_BEAT,  FC,           32'd1,         17'd102400, 3'd4, S_OK, 32'd0,         1'b0},
      '{ROW_BEAT,  FC,           32'd2,         17'd51200,  3'd5, S_OK, 32'd0,         1'b0},
      '{ROW_BEAT,  FC,           32'd3,         17'd1,      3'd1, S_RZ, 32'd0,         1'b0},
      '{ROW_BEAT,  FC,           32'hffff_ffff, 17'd0,      3'd0, S_RZ, 32'd0,         1'b0}
   };

   pwm_prescaler_reload_calc_unit #(
      .PRESCALER_BITS(PRESCALER_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req_payload),
      .rsp_strobe(rsp_strobe),
      .rsp_payload(rsp_payload),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // exact integer version of the prescaler search and the derived register values
   function automatic pwmrc_pkg::rsp_type calc_pwm_settings(input pwmrc_pkg::req_type beat);
      pwmrc_pkg::rsp_type res;
      logic [63:0] clk, freq, duty, lim, presc, reload, cmp, milli, duty_res;
      clk = {32'd0, clock_hz_setting};
      freq = {32'd0, beat.target_freq_hz};
      duty = {47'd0, beat.duty_request};
      lim = wide_setting ? {32'd0, pwmrc_pkg::LIM_WIDE} : {32'd0, pwmrc_pkg::LIM_NARROW};
      res = '0;
      res.channel_out = beat.channel_sel;
      res.duty_out = beat.duty_request;
      if (freq == 0) begin
         res.status = pwmrc_pkg::STATUS_ZERO_FREQ;
         return res;
      end
      res.status = pwmrc_pkg::STATUS_OK;
      // smallest prescaler with 2*clk < (2L+1)*p*f
      presc = ((2 * clk) / (2 * lim + 1)) / freq + 1;
      if (presc > PRESC_MAX) begin
         presc = PRESC_MAX;
         reload = lim;
         res.status = pwmrc_pkg::STATUS_PRESC_OVF;
      end else begin
         reload = ((2 * clk) / presc / freq + 1) >> 1;
         if (reload == 0) begin
            res.status = pwmrc_pkg::STATUS_RELOAD_ZERO;
            return res;
         end
      end
      cmp = (2 * duty * reload + 64'(pwmrc_pkg::FULL_DUTY)) / 64'(pwmrc_pkg::FULL_DUTY_X2);
      milli = ((64'(pwmrc_pkg::MILLI_X2) * clk) / presc / reload + 1) >> 1;
      duty_res = (64'(pwmrc_pkg::FULL_DUTY_X2) / reload + 1) >> 1;
      res.prescale_value = 16'(presc - 1);
      res.reload_value = 32'(reload - 1);
      // a compare that rounds to zero wraps to all ones
      res.compare_value = 32'(cmp - 1);
      res.achieved_freq_mhz = 42'(milli);
      res.duty_step = 17'(duty_res);
      return res;
   endfunction

   // random request, shaped towards prescaler steps and reload halves
   function automatic pwmrc_pkg::req_type random_request();
      pwmrc_pkg::req_type beat;
      logic [63:0] clk2, span, freq, reload;
      int unsigned pick;
      clk2 = {31'd0, clock_hz_setting, 1'b0};
      span = 2 * (wide_setting ? {32'd0, pwmrc_pkg::LIM_WIDE}
                               : {32'd0, pwmrc_pkg::LIM_NARROW}) + 1;
      beat.func = ($urandom_range(99) < 4) ? FUNC_IGNORED : pwmrc_pkg::FUNC_COMPUTE;
      pick = $urandom_range(99);
      if (pick < 3) begin
         freq = 0;
      end else if (pick < 6) begin
         freq = 64'hffff_ffff;
      end else if (pick < 24) begin
         // either side of a prescaler step, now and then past the largest prescaler
         freq = clk2 / (span * (($urandom() >> $urandom_range(31, 14)) + 1))
                + $urandom_range(1);
      end else if (pick < 38) begin
         // close to a reload that sits on a half
         reload = ($urandom() >> $urandom_range(31, 8)) + 1;
         freq = clk2 / (2 * reload + 1) + $urandom_range(1);
      end else begin
         // spread evenly over the magnitudes
         freq = $urandom() >> $urandom_range(31, 0);
      end
      beat.target_freq_hz = (freq > 64'hffff_ffff) ? 32'hffff_ffff : freq[31:0];
      pick = $urandom_range(99);
      if (pick < 8)
         beat.duty_request = '0;
      else if (pick < 16)
         beat.duty_request = 17'(pwmrc_pkg::FULL_DUTY);
      else if (pick < 22)
         beat.duty_request = 17'h1ffff;
      else if (pick < 32)
         beat.duty_request = 17'($urandom());
      else
         beat.duty_request = 17'($urandom_range(102400));
      beat.channel_sel = ($urandom_range(99) < 90) ? 3'($urandom_range(5))
                                                    : 3'($urandom_range(7, 6));
      return beat;
   endfunction

   // offer one beat until it is taken; start may drop while the block works
   task automatic send_beat(input pwmrc_pkg::req_type beat, input logic [1:0] fixed_status);
      pwmrc_pkg::rsp_type typed;
      bit taken;
      taken = 1'b0;
      while (!taken) begin
         if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clock);
         end else begin
            start <= 1'b1;
            req_payload <= beat;
            @(posedge clock);
            taken = !busy;
         end
      end
      // start stays high here, the next beat or a drain decides what comes next
      if (beat.func == pwmrc_pkg::FUNC_COMPUTE) begin
         if (fixed_status != pwmrc_pkg::STATUS_OK) begin
            typed = '0;
            typed.channel_out = beat.channel_sel;
            typed.duty_out = beat.duty_request;
            typed.status = fixed_status;
            settings_due.push_back(typed);
         end else begin
            settings_due.push_back(calc_pwm_settings(beat));
         end
      end
   endtask

   // let everything outstanding come back, then allow for a dropped beat still in flight
   task automatic drain();
      int unsigned waited;
      start <= 1'b0;
      waited = 0;
      while (settings_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY) @(posedge clock);
   endtask

   // write both registers while the block is idle
   task automatic configure(input logic [31:0] clk_hz, input logic wide);
      drain();
      csr_we <= 1'b1;
      csr_index <= pwmrc_pkg::CSR_CLOCK_HZ;
      csr_wdata <= clk_hz;
      @(posedge clock);
      csr_index <= pwmrc_pkg::CSR_WIDE;
      csr_wdata <= {31'd0, wide};
      @(posedge clock);
      csr_we <= 1'b0;
      clock_hz_setting = clk_hz;
      wide_setting = wide;
   endtask

   // result checker: one strobe, one beat, compared with the oldest expectation
   always @(posedge clock) begin
      pwmrc_pkg::rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         results_seen++;
         if (settings_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result beat %0d arrived with nothing outstanding", results_seen);
         end else begin
            want = settings_due.pop_front();
            if (rsp_payload !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("result beat %0d mismatch (expected / actual):", results_seen);
                  $display("  prescale %h / %h  reload %h / %h  compare %h / %h",
                           want.prescale_value, rsp_payload.prescale_value,
                           want.reload_value, rsp_payload.reload_value,
                           want.compare_value, rsp_payload.compare_value);
                  $display("  channel %0d / %0d  freq_mhz %0d / %0d  step %0d / %0d",
                           want.channel_out, rsp_payload.channel_out,
                           want.achieved_freq_mhz, rsp_payload.achieved_freq_mhz,
                           want.duty_step, rsp_payload.duty_step);
                  $display("  duty %0d / %0d  status %0d / %0d",
                           want.duty_out, rsp_payload.duty_out,
                           want.status, rsp_payload.status);
               end
            end
         end
      end
   end

   // main sequence
   initial begin
      pwmrc_pkg::req_type beat;
      int unsigned computed;
      logic [31:0] phase_clk;
      logic phase_wide;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed plan
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_SETUP) begin
            configure(plan[i].clk_hz, plan[i].wide);
         end else begin
            beat.func = plan[i].func;
            beat.target_freq_hz = plan[i].freq;
            beat.duty_request = plan[i].duty;
            beat.channel_sel = plan[i].chan;
            send_beat(beat, plan[i].fixed_status);
         end
      end

      // random phases across clock settings and both counter widths
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin phase_clk = pwmrc_pkg::CLOCK_HZ_RESET; phase_wide = 1'b0; end
            1: begin phase_clk = pwmrc_pkg::CLOCK_HZ_RESET; phase_wide = 1'b1; end
            2: begin phase_clk = 32'hffff_ffff;  phase_wide = 1'b0; end
            3: begin phase_clk = 32'hffff_ffff;  phase_wide = 1'b1; end
            4: begin phase_clk = 32'd1;          phase_wide = 1'b0; end
            5: begin phase_clk = 32'd0;          phase_wide = 1'b1; end
            default: begin
               phase_clk = ($urandom() >> $urandom_range(24, 0)) | 32'd1;
               phase_wide = 1'($urandom_range(1));
            end
         endcase
         configure(phase_clk, phase_wide);
         // one whole phase with start never dropped
         idle_pct = (phase == 1) ? 0 : 11;
         computed = 0;
         while (computed < ITEMS_PER_PHASE) begin
            beat = random_request();
            send_beat(beat, pwmrc_pkg::STATUS_OK);
            if (beat.func == pwmrc_pkg::FUNC_COMPUTE)
               computed++;
         end
      end

      drain();
      if (mismatches == 0 && settings_due.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #100_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: files.f
design/pwmrc_pkg.sv
design/pwmrc_serial_div.sv
design/pwmrc_serial_mul.sv
design/pwm_prescaler_reload_calc_unit.sv
bench/pwm_prescaler_reload_calc_unit_test.sv
